// ===== hw/rtl/timer_deadline_queue_unit_assert.svh =====
// Assertion macros for the timer deadline queue checker.
`ifndef TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define TDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TDQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/tdq_pkg.sv =====
// Types and constants shared by the timer deadline queue modules.
`default_nettype none
package tdq_pkg;

   // Most timers that one expire transaction may pop.
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_EXPIRE = 1'b1;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_FIRED = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;

   typedef struct packed {
      logic        func;
      logic [7:0]  handle;
      logic [63:0] deadline;
      logic [39:0] period;
      logic [63:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  fired_handle;
      logic        head_moved;
      logic [63:0] next_deadline;
      logic        queue_empty;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SUM,
      ST_INS,
      ST_ADD_RSP,
      ST_FIRE_RSP,
      ST_NONE_RSP
   } state_type;

   typedef struct packed {
      logic       add_req;
      logic       start_exp;
      logic       pop;
      logic       sum;
      logic       reins;
      logic       k_inc;
      logic       k_clr;
      logic       load_out;
      logic [1:0] out_sel;
   } cmd_type;

   typedef struct packed {
      logic head_due;
      logic n_full;
      logic n_zero;
      logic k_last;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tdq_controller.sv =====
// Sequencer that steps the timer queue datapath through adds and expiries.
`default_nettype none
module tdq_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_func,
   output logic                    req_ready,
   input  wire tdq_pkg::status_type status,
   output tdq_pkg::cmd_type        cmd
);

   tdq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         tdq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == tdq_pkg::FUNC_ADD) begin
                  cmd.add_req = 1'b1;
                  state_in    = tdq_pkg::ST_ADD_RSP;
               end else begin
                  cmd.start_exp = 1'b1;
                  state_in      = tdq_pkg::ST_POP;
               end
            end
         end
         tdq_pkg::ST_POP: begin
            if (status.head_due && !status.n_full) begin
               cmd.pop = 1'b1;
            end else if (status.n_zero) begin
               state_in = tdq_pkg::ST_NONE_RSP;
            end else begin
               state_in = tdq_pkg::ST_SUM;
            end
         end
         tdq_pkg::ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = tdq_pkg::ST_INS;
         end
         tdq_pkg::ST_INS: begin
            cmd.reins = 1'b1;
            if (status.k_last) begin
               cmd.k_clr = 1'b1;
               state_in  = tdq_pkg::ST_FIRE_RSP;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = tdq_pkg::ST_SUM;
            end
         end
         tdq_pkg::ST_ADD_RSP: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = tdq_pkg::KIND_ADD;
               state_in     = tdq_pkg::ST_IDLE;
            end
         end
         tdq_pkg::ST_FIRE_RSP: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = tdq_pkg::KIND_FIRED;
               if (status.k_last) begin
                  state_in = tdq_pkg::ST_IDLE;
               end else begin
                  cmd.k_inc = 1'b1;
               end
            end
         end
         tdq_pkg::ST_NONE_RSP: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = tdq_pkg::KIND_NONE;
               state_in     = tdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tdq_datapath.sv =====
// Sorted timer cell chain, pop buffer and result register of the timer queue.
`default_nettype none
module tdq_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tdq_pkg::req_type   req_data,
   input  wire tdq_pkg::cmd_type   cmd,
   output tdq_pkg::status_type     status,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output tdq_pkg::rsp_type        rsp_data
);

   localparam int OCC_W = $clog2(CAPACITY + 1);

   // Cell chain, kept sorted by deadline with the head in cell 0.
   logic [63:0] dl_ff [CAPACITY];
   logic [39:0] pr_ff [CAPACITY];
   logic [7:0]  hd_ff [CAPACITY];
   logic [63:0] dl_in [CAPACITY];
   logic [39:0] pr_in [CAPACITY];
   logic [7:0]  hd_in [CAPACITY];
   logic [OCC_W-1:0] occ_ff, occ_in;

   // Timers popped by the current expire transaction.
   logic [7:0]  buf_h [tdq_pkg::MAX_RESULTS];
   logic [39:0] buf_p [tdq_pkg::MAX_RESULTS];

   logic [tdq_pkg::CNT_W-1:0] n_ff, n_in;
   logic [tdq_pkg::IDX_W-1:0] k_ff, k_in;
   logic [63:0] now_ff;
   logic [63:0] sum_ff;
   logic [39:0] ins_p_ff;
   logic [7:0]  ins_h_ff;
   logic        ec_ff, ov_ff;
   logic        rsp_valid_ff;
   tdq_pkg::rsp_type rsp_ff, rsp_in;

   logic        full;
   logic        do_insert;
   logic [63:0] ins_d;
   logic [39:0] ins_p;
   logic [7:0]  ins_h;
   logic [CAPACITY-1:0] le, prev_le;
   logic [64:0] wide_sum;
   logic [63:0] sum_in;
   logic        k_last;

   assign full  = (occ_ff == OCC_W'(CAPACITY));
   assign ins_d = cmd.reins ? sum_ff   : req_data.deadline;
   assign ins_p = cmd.reins ? ins_p_ff : req_data.period;
   assign ins_h = cmd.reins ? ins_h_ff : req_data.handle;
   assign do_insert = !full && (cmd.add_req || (cmd.reins && (ins_p_ff != '0)));

   assign k_last = ((tdq_pkg::CNT_W'(k_ff) + tdq_pkg::CNT_W'(1)) == n_ff);

   assign wide_sum = {1'b0, now_ff} + {25'd0, buf_p[k_ff]};
   assign sum_in   = wide_sum[64] ? {64{1'b1}} : wide_sum[63:0];

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         le[i] = (OCC_W'(i) < occ_ff) && (dl_ff[i] <= ins_d);
      end
      prev_le[0] = 1'b1;
      for (int i = 1; i < CAPACITY; i++) begin
         prev_le[i] = le[i-1];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         dl_in[i] = dl_ff[i];
         pr_in[i] = pr_ff[i];
         hd_in[i] = hd_ff[i];
      end
      if (do_insert) begin
         occ_in = occ_ff + OCC_W'(1);
         for (int i = 0; i < CAPACITY; i++) begin
            if (!le[i]) begin
               if (prev_le[i]) begin
                  dl_in[i] = ins_d;
                  pr_in[i] = ins_p;
                  hd_in[i] = ins_h;
               end else begin
                  dl_in[i] = dl_ff[(i + CAPACITY - 1) % CAPACITY];
                  pr_in[i] = pr_ff[(i + CAPACITY - 1) % CAPACITY];
                  hd_in[i] = hd_ff[(i + CAPACITY - 1) % CAPACITY];
               end
            end
         end
      end else if (cmd.pop) begin
         occ_in = occ_ff - OCC_W'(1);
         for (int i = 0; i < CAPACITY - 1; i++) begin
            dl_in[i] = dl_ff[i+1];
            pr_in[i] = pr_ff[i+1];
            hd_in[i] = hd_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         dl_ff[i] <= dl_in[i];
         pr_ff[i] <= pr_in[i];
         hd_ff[i] <= hd_in[i];
      end
      if (cmd.pop) begin
         buf_h[n_ff[tdq_pkg::IDX_W-1:0]] <= hd_ff[0];
         buf_p[n_ff[tdq_pkg::IDX_W-1:0]] <= pr_ff[0];
      end
      if (cmd.start_exp) begin
         now_ff <= req_data.now;
      end
      if (cmd.sum) begin
         sum_ff   <= sum_in;
         ins_p_ff <= buf_p[k_ff];
         ins_h_ff <= buf_h[k_ff];
      end
      if (cmd.add_req) begin
         ec_ff <= !full && ((occ_ff == '0) || (req_data.deadline < dl_ff[0]));
         ov_ff <= full;
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      n_in = n_ff;
      k_in = k_ff;
      if (cmd.start_exp) begin
         n_in = '0;
         k_in = '0;
      end else begin
         if (cmd.pop) begin
            n_in = n_ff + tdq_pkg::CNT_W'(1);
         end
         if (cmd.k_clr) begin
            k_in = '0;
         end else if (cmd.k_inc) begin
            k_in = k_ff + tdq_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         n_ff   <= n_in;
         k_ff   <= k_in;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in                  = '0;
      rsp_in.kind             = cmd.out_sel;
      rsp_in.next_deadline    = (occ_ff != '0) ? dl_ff[0] : 64'd0;
      rsp_in.queue_empty      = (occ_ff == '0);
      rsp_in.last             = 1'b1;
      case (cmd.out_sel)
         tdq_pkg::KIND_ADD: begin
            rsp_in.head_moved = ec_ff;
            rsp_in.overflow   = ov_ff;
         end
         tdq_pkg::KIND_FIRED: begin
            rsp_in.fired_handle = buf_h[k_ff];
            rsp_in.last         = k_last;
         end
         default: begin
            rsp_in.last = 1'b1;
         end
      endcase
   end

   assign status.head_due = (occ_ff != '0) && (dl_ff[0] < now_ff);
   assign status.n_full   = (n_ff == tdq_pkg::CNT_W'(tdq_pkg::MAX_RESULTS));
   assign status.n_zero   = (n_ff == '0);
   assign status.k_last   = k_last;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/timer_deadline_queue_unit.sv =====
// Top level of the timer deadline queue: controller plus sorted-chain datapath.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-------------------------
//   req_    | in        | req_valid / req_ready | tdq_pkg::req_type
//   rsp_    | out       | rsp_valid / rsp_ready | tdq_pkg::rsp_type
//
// An add transaction inserts the timer into the sorted cell chain in the accept cycle,
// and its result is loaded into the output register once that register is free.
// An expire transaction pops due timers one per cycle from the chain head, then per
// popped timer does a saturating add and an insert step that puts repeating ones back,
// then gives one result per cycle while the output is free, or one if none was due.
// Reset clears the occupancy, the counters and the result valid; no clearing pass.
// A stalled result register holds the sequencer in its result state only.
`default_nettype none
module timer_deadline_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire tdq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output tdq_pkg::rsp_type      rsp_data
);

   // Command and status groups between the sequencer and the datapath.
   tdq_pkg::cmd_type    cmd;
   tdq_pkg::status_type status;

   // The sequencer takes a new transaction only in its idle state, so each
   // transaction runs to completion before the next one is looked at. A
   // finished result may still sit in the output register at that time.
   tdq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps the timers sorted by deadline, with equal deadlines
   // in insert order, and reports every result with the queue head as it
   // stands once all repeating timers have been put back.
   tdq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/tdq_checker.sv =====
// Port-level checker for the timer deadline queue, bound to the top level.
`default_nettype none
`include "timer_deadline_queue_unit_assert.svh"
module tdq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire tdq_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire tdq_pkg::rsp_type rsp_data
);

   `TDQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result transaction dropped or changed while stalled")

   `TDQ_ASSERT(a_empty_zero, rsp_valid && rsp_data.queue_empty |-> rsp_data.next_deadline == 64'd0, "empty queue reports a nonzero deadline")

   `TDQ_ASSERT(a_overflow_add, rsp_valid && rsp_data.overflow |-> rsp_data.kind == tdq_pkg::KIND_ADD && !rsp_data.head_moved && !rsp_data.queue_empty, "overflow flagged on a non-add or non-full result")

   `TDQ_ASSERT(a_single_last, rsp_valid && rsp_data.kind != tdq_pkg::KIND_FIRED |-> rsp_data.last && rsp_data.fired_handle == 8'd0, "add or idle expire result is not a single last result")

   `TDQ_ASSERT(a_busy_after_expire, req_valid && req_ready && req_data.func == tdq_pkg::FUNC_EXPIRE |=> !req_ready, "new transaction taken while an expire transaction is running")

endmodule

bind timer_deadline_queue_unit tdq_checker u_tdq_checker (.*);
`default_nettype wire

// ===== test/timer_deadline_queue_unit_tb.sv =====
// Self-checking testbench of the timer deadline queue unit, built around a mirror of its timer list.
`timescale 1ns / 100ps

// Software copy of the sorted timer list. It works out the results that every accepted
// transaction must produce, keeps them in order and checks each result against them.
class timer_queue_mirror;
   localparam int SLOTS = 16;

   bit [63:0]        slot_deadline [SLOTS];
   bit [39:0]        slot_period [SLOTS];
   bit [7:0]         slot_owner [SLOTS];
   int unsigned      queued;
   tdq_pkg::rsp_type awaited_results [$];
   int unsigned      field_errors;

   function new();
      queued = 0;
      field_errors = 0;
   endfunction

   // Insert behind every timer that is due at or before the new one.
   function void insert_timer(bit [7:0] owner, bit [63:0] deadline, bit [39:0] period);
      int unsigned pos;
      int unsigned i;
      if (queued >= SLOTS) return;
      pos = 0;
      while (pos < queued && slot_deadline[pos] <= deadline) pos++;
      for (i = queued; i > pos; i--) begin
         slot_deadline[i] = slot_deadline[i - 1];
         slot_period[i]   = slot_period[i - 1];
         slot_owner[i]    = slot_owner[i - 1];
      end
      slot_deadline[pos] = deadline;
      slot_period[pos]   = period;
      slot_owner[pos]    = owner;
      queued++;
   endfunction

   function void drop_head();
      int unsigned i;
      for (i = 1; i < queued; i++) begin
         slot_deadline[i - 1] = slot_deadline[i];
         slot_period[i - 1]   = slot_period[i];
         slot_owner[i - 1]    = slot_owner[i];
      end
      queued--;
   endfunction

   // Appends one owed result behind those already owed.
   function void owe_result(tdq_pkg::rsp_type res);
      awaited_results.insert(awaited_results.size(), res);
   endfunction

   // The status fields always describe the list once the whole transaction is done.
   function tdq_pkg::rsp_type status_result(bit [1:0] kind, bit [7:0] fired, bit changed,
                                            bit dropped, bit closing);
      tdq_pkg::rsp_type res;
      res.kind          = kind;
      res.fired_handle  = fired;
      res.head_moved    = changed;
      res.next_deadline = (queued != 0) ? slot_deadline[0] : 64'd0;
      res.queue_empty   = (queued == 0);
      res.overflow      = dropped;
      res.last          = closing;
      return res;
   endfunction

   function void forecast_results(tdq_pkg::req_type item);
      bit [7:0]    fired_owner [tdq_pkg::MAX_RESULTS];
      bit [39:0]   fired_period [tdq_pkg::MAX_RESULTS];
      bit [63:0]   restart;
      int unsigned popped;
      int unsigned k;
      bit          changed;
      if (item.func == tdq_pkg::FUNC_ADD) begin
         if (queued >= SLOTS) begin
            owe_result(status_result(tdq_pkg::KIND_ADD, 8'd0, 1'b0, 1'b1, 1'b1));
         end else begin
            changed = (queued == 0) || (item.deadline < slot_deadline[0]);
            insert_timer(item.handle, item.deadline, item.period);
            owe_result(status_result(tdq_pkg::KIND_ADD, 8'd0, changed, 1'b0, 1'b1));
         end
      end else begin
         popped = 0;
         while (popped < tdq_pkg::MAX_RESULTS && queued > 0 && slot_deadline[0] < item.now) begin
            fired_owner[popped]  = slot_owner[0];
            fired_period[popped] = slot_period[0];
            drop_head();
            popped++;
         end
         // Repeating timers go back only after every pop, in pop order, saturating at the top.
         for (k = 0; k < popped; k++) begin
            if (fired_period[k] != 40'd0) begin
               restart = item.now + {24'd0, fired_period[k]};
               if (restart < item.now) restart = '1;
               insert_timer(fired_owner[k], restart, fired_period[k]);
            end
         end
         if (popped == 0) begin
            owe_result(status_result(tdq_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0, 1'b1));
         end else begin
            for (k = 0; k < popped; k++) begin
               owe_result(status_result(tdq_pkg::KIND_FIRED, fired_owner[k], 1'b0, 1'b0,
                                        k == popped - 1));
            end
         end
      end
   endfunction

   function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
      if (seen !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, seen);
         field_errors++;
      end
   endfunction

   function void match_result(tdq_pkg::rsp_type seen);
      tdq_pkg::rsp_type want;
      if (awaited_results.size() == 0) begin
         $display("%0t: result expected none, got %h", $time, seen);
         field_errors++;
         return;
      end
      want = awaited_results.pop_front();
      compare_field("kind", 64'(want.kind), 64'(seen.kind));
      compare_field("fired_handle", 64'(want.fired_handle), 64'(seen.fired_handle));
      compare_field("head_moved", 64'(want.head_moved), 64'(seen.head_moved));
      compare_field("next_deadline", want.next_deadline, seen.next_deadline);
      compare_field("queue_empty", 64'(want.queue_empty), 64'(seen.queue_empty));
      compare_field("overflow", 64'(want.overflow), 64'(seen.overflow));
      compare_field("last", 64'(want.last), 64'(seen.last));
   endfunction
endclass

module testbench;
   import tdq_pkg::*;

   localparam int SLOTS = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;

   // Set for the closing part of the run, in which neither side idles.
   bit          steady = 1'b0;
   // Running wall time of the random part. It only moves forward, so that timers queued
   // ahead of it are swept out again by a later expire transaction.
   bit [63:0]   wall_us = 64'd0;
   int unsigned items_sent = 0;

   timer_queue_mirror mirror = new();

   timer_deadline_queue_unit #(
      .CAPACITY(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // The fields that a transaction ignores always carry noise, so that every bit of them moves.
   function automatic req_type add_item(bit [7:0] owner, bit [63:0] deadline, bit [39:0] period);
      req_type item;
      item.func     = FUNC_ADD;
      item.handle   = owner;
      item.deadline = deadline;
      item.period   = period;
      item.now      = random_word();
      return item;
   endfunction

   function automatic req_type expire_item(bit [63:0] now);
      req_type   item;
      bit [63:0] noise;
      noise         = random_word();
      item.func     = FUNC_EXPIRE;
      item.handle   = noise[7:0];
      item.deadline = random_word();
      item.period   = noise[63:24];
      item.now      = now;
      return item;
   endfunction

   // Mostly one-shot timers and short repeats; now and then a long repeat of any size.
   function automatic bit [39:0] random_period();
      int unsigned pick;
      bit [63:0]   noise;
      pick  = $urandom_range(0, 19);
      noise = random_word();
      if (pick < 10) return 40'd0;
      if (pick < 17) return 40'($urandom_range(1, 3000));
      if (pick < 19) return noise[39:0];
      return 40'd1;
   endfunction

   // Deadlines cluster around the wall time: some ahead, some already overdue, some tied
   // with each other, a few far ahead and a few at zero.
   function automatic bit [63:0] random_deadline();
      int unsigned pick;
      bit [63:0]   noise;
      pick  = $urandom_range(0, 19);
      noise = random_word();
      if (pick < 12) return wall_us + $urandom_range(0, 2000);
      if (pick < 15) return wall_us - $urandom_range(0, 2000);
      if (pick < 17) return wall_us + $urandom_range(0, 3);
      if (pick < 19) return wall_us + {24'd0, noise[39:0]};
      return 64'd0;
   endfunction

   // Offers one transaction, perhaps after an idle burst, and returns at the edge that
   // accepts it. Valid stays high at that edge: the caller either offers the next
   // transaction at once or lowers valid itself.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = 0;
      if (!steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      mirror.forecast_results(item);
      items_sent++;
   endtask

   // Holds the sender back until every result that is owed has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.awaited_results.size() != 0);
   endtask

   // Fills the queue to the top, offers one more timer that must be dropped, then jumps the
   // wall time far enough that everything queued is overdue and sweeps it in one expire.
   task automatic fill_and_sweep();
      bit [63:0] noise;
      wait_drained();
      while (mirror.queued < SLOTS) begin
         send_item(add_item(8'($urandom_range(0, 255)), random_deadline(), random_period()));
      end
      send_item(add_item(8'($urandom_range(0, 255)), random_deadline(), random_period()));
      noise   = random_word();
      wall_us = wall_us + 64'h0000_0200_0000_0000 + {40'd0, noise[23:0]};
      send_item(expire_item(wall_us));
   endtask

   task automatic random_step();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         fill_and_sweep();
      end else if (pick < 58) begin
         // Now and then let the block run dry before the next add.
         if (pick < 9) wait_drained();
         send_item(add_item(8'($urandom_range(0, 255)), random_deadline(), random_period()));
      end else begin
         // Most expire transactions move the wall time on; some repeat the last one.
         if (pick < 92) wall_us = wall_us + $urandom_range(1, 1500);
         send_item(expire_item(wall_us));
      end
   endtask

   // Result side: stalls come in bursts, with calm stretches in between.
   initial begin : rsp_side
      int unsigned hold;
      forever begin
         @(posedge clock);
         if (!steady && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 16);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 63) == 0) begin
            hold = $urandom_range(50, 200);
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Every accepted result is checked against the oldest result that is owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) mirror.match_result(rsp_data);
   end

   initial begin : stimulus
      int unsigned i;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Nothing can expire from an empty queue, even at the latest possible time.
      send_item(expire_item('1));
      // The first add always moves the head, a strictly earlier one moves it again, and an
      // equal deadline does not: it queues behind the first of the pair.
      send_item(add_item(8'd1, 64'd1000, 40'd0));
      send_item(add_item(8'd2, 64'd500, 40'd0));
      send_item(add_item(8'd3, 64'd500, 40'd0));
      send_item(add_item(8'd0, 64'd0, 40'd5));
      // Expiry is strictly before now, so a timer due at zero does not fire at zero.
      send_item(expire_item(64'd0));
      // Three fire; the repeating one comes back at now plus its period.
      send_item(expire_item(64'd501));
      // Fill the queue, then an add that finds it full is dropped.
      for (i = 0; i < 14; i++) begin
         send_item(add_item(8'($urandom_range(0, 255)), 64'($urandom_range(2000, 1000000)),
                            (i % 4 == 0) ? 40'($urandom_range(1, 100)) : 40'd0));
      end
      send_item(add_item(8'hA5, 64'd0, 40'd0));
      // All sixteen timers are due at once: the most that one expire transaction can pop.
      send_item(expire_item(64'h0000_0100_0000_0000));

      // Random part, starting well past every deadline queued so far.
      wall_us = 64'h0000_1000_0000_0000;
      fill_and_sweep();
      while (items_sent < 140) random_step();

      // Closing part with no idling on either side.
      steady = 1'b1;
      for (i = 0; i < 20; i++) random_step();
      // Extreme fields, then restart times that run past the top of the time range and
      // saturate there. Timers due at the very top can never expire, so they come last.
      send_item(add_item(8'hFF, '1, '1));
      send_item(add_item(8'd7, 64'd10, '1));
      send_item(expire_item(64'hFFFF_FFFF_FFFF_FFFC));
      send_item(expire_item('1));

      wait_drained();
      repeat (20) @(posedge clock);
      if (mirror.field_errors == 0 && mirror.awaited_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // A correct run takes well under a millisecond of simulated time.
   initial begin : watchdog
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tdq_pkg.sv
hw/rtl/tdq_controller.sv
hw/rtl/tdq_datapath.sv
hw/rtl/timer_deadline_queue_unit.sv
hw/rtl/tdq_checker.sv
test/timer_deadline_queue_unit_tb.sv
